// ===== sv/raycast_wall_column_setup_core_macros.svh =====
// ----------------------------------------------------------------------------
// Raycast wall column setup - assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef RAYCAST_WALL_COLUMN_SETUP_CORE_MACROS_SVH
`define RAYCAST_WALL_COLUMN_SETUP_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define RWCS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rwcs assertion failed");
// Consequent must hold in the cycle after the antecedent.
`define RWCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rwcs assertion failed");
`else
`define RWCS_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define RWCS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/rwcs_pkg.sv =====
// ----------------------------------------------------------------------------
// Raycast wall column setup - package
// Pipeline record, stage map and the divider step functions.
// ----------------------------------------------------------------------------
package rwcs_pkg;

  localparam int FRAC_BITS = 16;
  localparam int TEX_BITS  = 7;
  localparam int DIV1_BITS = 12 + FRAC_BITS;          // quotient bits of line height
  localparam int DIV2_BITS = TEX_BITS + FRAC_BITS + 1; // quotient bits of texture step
  localparam logic [11:0] H_RESET = 12'd480;
  localparam logic [23:0] Q24_MAX = 24'hFFFFFF;

  // Stage map of the pipeline.
  localparam int ST_DIV1    = 1;
  localparam int ST_LINE    = ST_DIV1 + DIV1_BITS;
  localparam int ST_DIV2    = ST_LINE + 1;
  localparam int ST_MUL     = ST_DIV2 + DIV2_BITS;
  localparam int ST_OUT     = ST_MUL + 1;
  localparam int NUM_STAGES = ST_OUT + 1;

  localparam logic [1:0] FACE_NORTH = 2'd0;
  localparam logic [1:0] FACE_SOUTH = 2'd1;
  localparam logic [1:0] FACE_WEST  = 2'd2;
  localparam logic [1:0] FACE_EAST  = 2'd3;

  // Everything one column carries down the pipeline.
  typedef struct packed {
    logic [11:0]          col;
    logic [11:0]          h;
    logic [31:0]          wdist;
    logic [1:0]           face;
    logic                 fvld;
    logic                 mirror;
    logic [15:0]          pfrac;
    logic [31:0]          wall;
    logic [TEX_BITS-1:0]  tex;
    logic [DIV1_BITS-1:0] num;
    logic [32:0]          rem1;
    logic [DIV1_BITS-1:0] q1;
    logic [23:0]          lh;
    logic [11:0]          start;
    logic [11:0]          dend;
    logic [22:0]          off;
    logic [23:0]          dvs;
    logic [24:0]          rem2;
    logic [DIV2_BITS-1:0] q2;
    logic [46:0]          tprod;
  } col_pipe_t;

  // One restoring step of the line height division, quotient bit idx.
  function automatic col_pipe_t div1_step(col_pipe_t p, int idx);
    logic [32:0] r;
    col_pipe_t   o;
    o = p;
    r = {p.rem1[31:0], p.num[idx]};
    if (r >= {1'b0, p.wdist}) begin
      o.rem1    = r - {1'b0, p.wdist};
      o.q1[idx] = 1'b1;
    end else begin
      o.rem1    = r;
      o.q1[idx] = 1'b0;
    end
    return o;
  endfunction

  // One restoring step of the texture step division; the dividend is a
  // single one at its top bit.
  function automatic col_pipe_t div2_step(col_pipe_t p, int idx);
    logic [24:0] r;
    col_pipe_t   o;
    o = p;
    r = {p.rem2[23:0], (idx == DIV2_BITS - 1)};
    if (r >= {1'b0, p.dvs}) begin
      o.rem2    = r - {1'b0, p.dvs};
      o.q2[idx] = 1'b1;
    end else begin
      o.rem2    = r;
      o.q2[idx] = 1'b0;
    end
    return o;
  endfunction

endpackage

// ===== sv/raycast_wall_column_setup_core.sv =====
// Throughput: one column per cycle while the output is not stalled; two
// bit-serial divider chains (28 and 24 stages, one quotient bit per stage)
// set the depth, not the rate.
// A stalled output holds the whole pipeline; nothing is lost or repeated.
// Reset (rst_n low, synchronous) empties the pipeline and sets screen
// height to 480.
// ----------------------------------------------------------------------------
// Raycast wall column setup core
// Per screen column: line height, draw rows, texture column, step and face.
// ----------------------------------------------------------------------------
`include "raycast_wall_column_setup_core_macros.svh"

module raycast_wall_column_setup_core (
  input  logic         clk,
  input  logic         rst_n,
  // Configuration: screen height.
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [11:0]  cfg_data,
  // Input channel.
  input  logic         in_tvalid,
  output logic         in_tready,
  // column, wall_distance, dir_x, dir_y, player_x, player_y, pad
  input  logic [135:0] in_tdata,
  // hit_side
  input  logic [0:0]   in_tuser,
  // Result channel.
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_column, start_row, end_row, texture_column, texture_step,
  // texture_start, wall_face, pad
  output logic [95:0]  out_tdata,
  // face_valid
  output logic [0:0]   out_tuser
);

  localparam int NS = rwcs_pkg::NUM_STAGES;

  logic [11:0]         h_r;
  logic                en;
  logic                vld_r  [NS];
  rwcs_pkg::col_pipe_t pipe_r   [NS];
  rwcs_pkg::col_pipe_t pipe_nxt [NS];

  // Screen height register, always writable.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_r <= rwcs_pkg::H_RESET;
    end else if (cfg_valid) begin
      h_r <= cfg_data;
    end
  end

  // Whole pipeline advances unless the result waits.
  assign en        = !vld_r[NS-1] || out_tready;
  assign in_tready = en;

  // Entry stage: unpack, face, direction product.
  always_comb begin
    logic               side;
    logic signed [19:0] dx;
    logic signed [19:0] dy;
    logic signed [19:0] dsel;
    logic [23:0]        psel;
    logic signed [52:0] prod;
    side = in_tuser[0];
    dx   = $signed(in_tdata[63:44]);
    dy   = $signed(in_tdata[83:64]);
    dsel = side ? dx : dy;
    psel = side ? in_tdata[107:84] : in_tdata[131:108];
    prod = $signed({1'b0, in_tdata[43:12]}) * dsel;
    pipe_nxt[0]       = '0;
    pipe_nxt[0].col   = in_tdata[11:0];
    pipe_nxt[0].h     = h_r;
    pipe_nxt[0].wdist = in_tdata[43:12];
    pipe_nxt[0].num   = {h_r, {rwcs_pkg::FRAC_BITS{1'b0}}};
    pipe_nxt[0].pfrac = psel[15:0];
    pipe_nxt[0].wall  = prod[31:0];
    pipe_nxt[0].mirror = (!side && dx > 0) || (side && dy < 0);
    if (side) begin
      pipe_nxt[0].fvld = (dy != 0);
      pipe_nxt[0].face = (dy < 0) ? rwcs_pkg::FACE_SOUTH : rwcs_pkg::FACE_NORTH;
    end else begin
      pipe_nxt[0].fvld = (dx != 0);
      if (dx < 0) begin
        pipe_nxt[0].face = rwcs_pkg::FACE_WEST;
      end else if (dx > 0) begin
        pipe_nxt[0].face = rwcs_pkg::FACE_EAST;
      end else begin
        pipe_nxt[0].face = rwcs_pkg::FACE_NORTH;
      end
    end
  end

  // Later stages.
  for (genvar k = 1; k < NS; k++) begin : g_stage
    if (k < rwcs_pkg::ST_LINE) begin : g_div1
      always_comb begin
        rwcs_pkg::col_pipe_t t;
        logic [31:0]         w;
        t = pipe_r[k-1];
        w = t.wall + {t.pfrac, 16'h0000};
        // First divider stage also finishes the texture column.
        if (k == rwcs_pkg::ST_DIV1) begin
          t.tex = t.mirror ? ~w[31:32-rwcs_pkg::TEX_BITS] : w[31:32-rwcs_pkg::TEX_BITS];
        end
        pipe_nxt[k] = rwcs_pkg::div1_step(t, rwcs_pkg::ST_LINE - 1 - k);
      end
    end else if (k == rwcs_pkg::ST_LINE) begin : g_line
      // Saturate line height, then draw rows and texture offset.
      always_comb begin
        rwcs_pkg::col_pipe_t t;
        logic [22:0]         l2;
        logic [22:0]         h2;
        logic [23:0]         sum;
        t   = pipe_r[k-1];
        t.lh = (t.q1 > {4'h0, rwcs_pkg::Q24_MAX}) ? rwcs_pkg::Q24_MAX : t.q1[23:0];
        l2  = t.lh[23:1];
        h2  = {12'h000, t.h[11:1]};
        sum = {1'b0, l2} + {1'b0, h2};
        if (l2 > h2) begin
          t.start = '0;
          t.off   = l2 - h2;
        end else begin
          t.start = h2[11:0] - l2[11:0];
          t.off   = '0;
        end
        if (t.h == 12'd0) begin
          t.dend = '0;
        end else if (sum >= {12'h000, t.h}) begin
          t.dend = t.h - 12'd1;
        end else begin
          t.dend = sum[11:0];
        end
        t.dvs  = (t.lh == 24'd0) ? 24'd1 : t.lh;
        t.rem2 = '0;
        pipe_nxt[k] = t;
      end
    end else if (k < rwcs_pkg::ST_MUL) begin : g_div2
      always_comb begin
        pipe_nxt[k] = rwcs_pkg::div2_step(pipe_r[k-1], rwcs_pkg::ST_MUL - 1 - k);
      end
    end else if (k == rwcs_pkg::ST_MUL) begin : g_mul
      always_comb begin
        pipe_nxt[k]       = pipe_r[k-1];
        pipe_nxt[k].tprod = pipe_r[k-1].off * pipe_r[k-1].q2;
      end
    end else begin : g_sat
      // Texture start saturates at the top of Q8.16.
      always_comb begin
        pipe_nxt[k] = pipe_r[k-1];
        if (pipe_r[k-1].tprod > {23'h0, rwcs_pkg::Q24_MAX}) begin
          pipe_nxt[k].tprod = {23'h0, rwcs_pkg::Q24_MAX};
        end
      end
    end
  end

  // Stage registers with their valid bits.
  for (genvar k = 0; k < NS; k++) begin : g_reg
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= (k == 0) ? in_tvalid : vld_r[(k == 0) ? 0 : k-1];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        pipe_r[k] <= pipe_nxt[k];
      end
    end
  end

  // Result packing.
  assign out_tvalid = vld_r[NS-1];
  assign out_tdata  = {3'b000,
                       pipe_r[NS-1].face,
                       pipe_r[NS-1].tprod[23:0],
                       pipe_r[NS-1].q2,
                       pipe_r[NS-1].tex,
                       pipe_r[NS-1].dend,
                       pipe_r[NS-1].start,
                       pipe_r[NS-1].col};
  assign out_tuser  = pipe_r[NS-1].fvld;

  // Checks.
  `RWCS_ASSERT_NOW(a_stall_only_when_full, clk, rst_n, !in_tready, out_tvalid)
  `RWCS_ASSERT_NOW(a_no_face_is_zero, clk, rst_n, out_tvalid && !out_tuser[0],
                   out_tdata[92:91] == rwcs_pkg::FACE_NORTH)
  `RWCS_ASSERT_NOW(a_step_range, clk, rst_n, out_tvalid,
                   out_tdata[66:43] <= 24'h800000)
  `RWCS_ASSERT_NOW(a_rows_ordered, clk, rst_n, out_tvalid,
                   out_tdata[23:12] <= out_tdata[35:24])
  `RWCS_ASSERT_NEXT(a_stall_holds, clk, rst_n, out_tvalid && !out_tready,
                    out_tvalid)

endmodule
